>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Assertion that also watches the reset cycles
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> hw/rtl/bmft_pkg.sv
// Types and command codes of the block-mapped flash translation layer
package bmft_pkg;

  localparam logic [2:0] CMD_PROG  = 3'd0;
  localparam logic [2:0] CMD_COPY  = 3'd1;
  localparam logic [2:0] CMD_ERASE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_MISS  = 3'd4;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] sector_addr;
  } in_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] page_addr;
    logic [7:0] source_page;
    logic [4:0] erase_block;
    logic       last;
  } out_t;

endpackage

>>> hw/rtl/block_mapped_flash_translation_top.sv
// Block-mapped flash translation layer: sequencer around the map and page RAMs
//
// Each accepted item (start while busy is low) is a sector read or write; the
// block answers with flash commands, at most one per cycle, on out_valid/out_data,
// the final one flagged by last, and out_valid cannot be held off. The sequencer
// works through the page RAM port one page at a time, in a read state and a
// check state per page, when scanning: a read scans at most the fill count
// pages; an append write scans the filled pages, then programs; a write to a full
// block runs an invalidate scan, a copy scan and an erase sweep, and gives up to
// PAGES_IN_BLOCK + 1 commands. An out-of-range write gives no command. After
// reset a clearing pass over all PHYS_BLOCKS*PAGES_IN_BLOCK page entries runs
// with busy high.
module block_mapped_flash_translation_top
  import bmft_pkg::*;
#(
  parameter int PAGES_IN_BLOCK = 8,
  parameter int PHYS_BLOCKS    = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int DATA_BLOCKS = PHYS_BLOCKS - 1;
  localparam int TOTAL_PAGES = PHYS_BLOCKS * PAGES_IN_BLOCK;
  localparam int PW  = $clog2(PAGES_IN_BLOCK);
  localparam int BW  = $clog2(PHYS_BLOCKS);
  localparam int FW  = $clog2(PAGES_IN_BLOCK + 1);
  localparam int PAW = $clog2(TOTAL_PAGES);
  localparam int MW  = 1 + BW + FW;
  localparam int LW  = 8 - PW;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MAP  = 4'd2;
  localparam logic [3:0] S_SRD  = 4'd3;
  localparam logic [3:0] S_SCHK = 4'd4;
  localparam logic [3:0] S_PROG = 4'd5;
  localparam logic [3:0] S_CRD  = 4'd6;
  localparam logic [3:0] S_CCHK = 4'd7;
  localparam logic [3:0] S_ERA  = 4'd8;

  logic [3:0]     state_r, state_nxt;
  logic           func_r, func_nxt;
  logic           inr_r, inr_nxt;
  logic [BW-1:0]  lb_r, lb_nxt;
  logic [PW-1:0]  tag_r, tag_nxt;
  logic [BW-1:0]  blk_r, blk_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic           full_r, full_nxt;
  logic [FW-1:0]  lim_r, lim_nxt;
  logic [FW-1:0]  i_r, i_nxt;
  logic [FW-1:0]  n_r, n_nxt;
  logic [PAW-1:0] base_r, base_nxt;
  logic [PAW-1:0] dst_r, dst_nxt;
  logic [PAW-1:0] clr_r, clr_nxt;
  logic [BW-1:0]  spare_r, spare_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_t           out_r, out_nxt;

  logic           mw_en;
  logic [BW-1:0]  mw_addr, mr_addr;
  logic [MW-1:0]  mw_data, mr_data;
  logic           pw_en;
  logic [PAW-1:0] pw_addr, pr_addr;
  logic [PW:0]    pw_data, pr_data;

  logic [LW-1:0]  in_lb;
  logic           m_used;
  logic [BW-1:0]  m_blk;
  logic [FW-1:0]  m_fill;
  logic           p_valid;
  logic [PW-1:0]  p_tag;
  logic [PAW-1:0] cur_page;

  bmft_ram #(.DEPTH(DATA_BLOCKS), .WIDTH(MW), .AW(BW)) u_map_ram (
    .clk(clk), .we(mw_en), .waddr(mw_addr), .wdata(mw_data),
    .raddr(mr_addr), .rdata(mr_data)
  );

  bmft_ram #(.DEPTH(TOTAL_PAGES), .WIDTH(PW + 1), .AW(PAW)) u_page_ram (
    .clk(clk), .we(pw_en), .waddr(pw_addr), .wdata(pw_data),
    .raddr(pr_addr), .rdata(pr_data)
  );

  assign in_lb    = in_data.sector_addr[7:PW];
  assign m_used   = mr_data[MW-1];
  assign m_blk    = mr_data[FW+BW-1:FW];
  assign m_fill   = mr_data[FW-1:0];
  assign p_valid  = pr_data[PW];
  assign p_tag    = pr_data[PW-1:0];
  assign cur_page = base_r + PAW'(i_r);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    inr_nxt       = inr_r;
    lb_nxt        = lb_r;
    tag_nxt       = tag_r;
    blk_nxt       = blk_r;
    fill_nxt      = fill_r;
    full_nxt      = full_r;
    lim_nxt       = lim_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    base_nxt      = base_r;
    dst_nxt       = dst_r;
    clr_nxt       = clr_r;
    spare_nxt     = spare_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    mw_en         = 1'b0;
    mw_addr       = lb_r;
    mw_data       = '0;
    mr_addr       = lb_r;
    pw_en         = 1'b0;
    pw_addr       = cur_page;
    pw_data       = '0;
    pr_addr       = cur_page;

    case (state_r)
      S_CLR: begin
        pw_en   = 1'b1;
        pw_addr = clr_r;
        if (32'(clr_r) < DATA_BLOCKS) begin
          mw_en   = 1'b1;
          mw_addr = clr_r[BW-1:0];
        end
        if (32'(clr_r) == TOTAL_PAGES - 1) begin
          state_nxt = S_IDLE;
        end
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        mr_addr = BW'(in_lb);
        if (start) begin
          func_nxt  = in_data.func;
          inr_nxt   = 32'(in_lb) < DATA_BLOCKS;
          lb_nxt    = BW'(in_lb);
          tag_nxt   = in_data.sector_addr[PW-1:0];
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        // an unused entry maps the identity block with no pages yet
        blk_nxt  = m_used ? m_blk : lb_r;
        fill_nxt = m_used ? m_fill : '0;
        base_nxt = PAW'(32'(m_used ? m_blk : lb_r) * PAGES_IN_BLOCK);
        dst_nxt  = PAW'(32'(spare_r) * PAGES_IN_BLOCK);
        full_nxt = m_used && (32'(m_fill) >= PAGES_IN_BLOCK);
        i_nxt    = '0;
        if (func_r == FUNC_READ) begin
          lim_nxt = m_fill;
          if (!inr_r || !m_used || m_fill == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt.cmd   = CMD_MISS;
            out_nxt.last  = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_SRD;
          end
        end else if (!inr_r) begin
          state_nxt = S_IDLE;
        end else if (m_used && (32'(m_fill) >= PAGES_IN_BLOCK)) begin
          lim_nxt   = FW'(PAGES_IN_BLOCK);
          state_nxt = S_SRD;
        end else begin
          lim_nxt   = m_used ? m_fill : '0;
          state_nxt = (m_used && m_fill != '0) ? S_SRD : S_PROG;
        end
      end
      S_SRD: begin
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        i_nxt     = i_r + 1'b1;
        state_nxt = S_SRD;
        if (func_r == FUNC_READ) begin
          if (p_valid && p_tag == tag_r) begin
            out_valid_nxt     = 1'b1;
            out_nxt.cmd       = CMD_READ;
            out_nxt.page_addr = 8'(cur_page);
            out_nxt.last      = 1'b1;
            state_nxt         = S_IDLE;
          end else if (i_r + 1'b1 == lim_r) begin
            out_valid_nxt = 1'b1;
            out_nxt.cmd   = CMD_MISS;
            out_nxt.last  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          // drop older copies of this sector
          if (p_valid && p_tag == tag_r) begin
            pw_en   = 1'b1;
            pw_data = {1'b0, tag_r};
          end
          if (i_r + 1'b1 == lim_r) begin
            state_nxt = S_PROG;
          end
        end
      end
      S_PROG: begin
        pw_en             = 1'b1;
        pw_data           = {1'b1, tag_r};
        out_valid_nxt     = 1'b1;
        out_nxt.cmd       = CMD_PROG;
        if (!full_r) begin
          pw_addr           = base_r + PAW'(fill_r);
          mw_en             = 1'b1;
          mw_data           = {1'b1, blk_r, fill_r + 1'b1};
          out_nxt.page_addr = 8'(base_r + PAW'(fill_r));
          out_nxt.last      = 1'b1;
          state_nxt         = S_IDLE;
        end else begin
          pw_addr           = dst_r;
          out_nxt.page_addr = 8'(dst_r);
          i_nxt             = '0;
          n_nxt             = FW'(1);
          state_nxt         = S_CRD;
        end
      end
      S_CRD: begin
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (p_valid && 32'(n_r) < PAGES_IN_BLOCK) begin
          pw_en               = 1'b1;
          pw_addr             = dst_r + PAW'(n_r);
          pw_data             = {1'b1, p_tag};
          out_valid_nxt       = 1'b1;
          out_nxt.cmd         = CMD_COPY;
          out_nxt.page_addr   = 8'(dst_r + PAW'(n_r));
          out_nxt.source_page = 8'(cur_page);
          n_nxt               = n_r + 1'b1;
        end
        i_nxt = i_r + 1'b1;
        if (32'(i_r) == PAGES_IN_BLOCK - 1) begin
          i_nxt     = '0;
          state_nxt = S_ERA;
        end else begin
          state_nxt = S_CRD;
        end
      end
      S_ERA: begin
        pw_en = 1'b1;
        i_nxt = i_r + 1'b1;
        if (32'(i_r) == PAGES_IN_BLOCK - 1) begin
          // swap the old block and the spare
          mw_en               = 1'b1;
          mw_data             = {1'b1, spare_r, n_r};
          spare_nxt           = blk_r;
          out_valid_nxt       = 1'b1;
          out_nxt.cmd         = CMD_ERASE;
          out_nxt.erase_block = 5'(blk_r);
          out_nxt.last        = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      spare_r     <= BW'(PHYS_BLOCKS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      spare_r     <= spare_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    inr_r  <= inr_nxt;
    lb_r   <= lb_nxt;
    tag_r  <= tag_nxt;
    blk_r  <= blk_nxt;
    fill_r <= fill_nxt;
    full_r <= full_nxt;
    lim_r  <= lim_nxt;
    i_r    <= i_nxt;
    n_r    <= n_nxt;
    base_r <= base_nxt;
    dst_r  <= dst_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/bmft_ram.sv
// Generic single-write, single-read synchronous RAM with registered read
module bmft_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bmft_checker.sv
// Port-level checker for the flash translation top level, with its bind
`include "assert_macros.svh"

module bmft_checker
  import bmft_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);

  `CHK_ASSERT_ALWAYS(a_busy_after_reset, clk, !rst_n |=> busy)
  `CHK_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  `CHK_ASSERT(a_last_frees, clk, rst_n, (out_valid && out_data.last) |-> !busy)
  `CHK_ASSERT(a_more_busy, clk, rst_n, (out_valid && !out_data.last) |-> busy)
  `CHK_ASSERT(a_erase_last, clk, rst_n, (out_valid && out_data.cmd == CMD_ERASE) |-> out_data.last)

endmodule

bind block_mapped_flash_translation_top bmft_checker u_bmft_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
